// ===== rtl/tfc_pkg.sv =====
// Package for the transfer-function colormap: payload types, sizes, codes.
// Used by transfer_function_colormap.
`timescale 1ns / 1ps
package tfc_pkg;
    localparam int POINT_MAX = 16;
    localparam int MAP_MAX   = 256;
    localparam int ISO_MAX   = 8;
    localparam int PW = $clog2(POINT_MAX);
    localparam int MW = $clog2(MAP_MAX);
    localparam int IW = $clog2(ISO_MAX);
    localparam logic [15:0] ISO_ALPHA = 16'd64880;
    localparam logic [15:0] ALPHA_RST = 16'd32768;
    localparam logic [8:0]  RES_RST   = 9'd256;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_CLRPTS = 3'd1;
    localparam logic [2:0] CMD_WALPHA = 3'd2;
    localparam logic [2:0] CMD_ADDISO = 3'd3;
    localparam logic [2:0] CMD_CLRISO = 3'd4;
    localparam logic [2:0] CMD_LOOKUP = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;
    localparam logic [1:0] ST_NOPT = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] position;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [7:0]  entry_index;
        logic [15:0] alpha_in;
    } t_in;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
        logic        entry_valid;
        logic [1:0]  status;
    } t_out;

    // point store word: position and colour
    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_point;

    // reset contents of the point store
    function automatic t_point rst_point(input logic [PW-1:0] k);
        t_point p;
        p = '0;
        case (k)
            PW'(0): p = '{16'd0,     16'd3341,  16'd33924, 16'd54227};
            PW'(1): p = '{16'd32768, 16'd62708, 16'd53456, 16'd6939};
            PW'(2): p = '{16'd65535, 16'd49858, 16'd19275, 16'd16448};
            default: p = '0;
        endcase
        return p;
    endfunction
endpackage

// ===== rtl/tfc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/tfc_div.sv =====
// Restoring divider, one quotient bit per cycle: 32-bit dividend / 17-bit divisor.
// Uses nothing from the package.
`timescale 1ns / 1ps
module tfc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    logic [31:0] r_q;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    always_comb w_sh = {r_rem[16:0], r_q[31]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule

// ===== rtl/transfer_function_colormap.sv =====
// Top level of the transfer-function colormap: sequencer, stores, lookup.
// Depends on tfc_pkg, tfc_ram and tfc_div.
//
//  channel  dir  handshake           payload
//  in       in   i_valid / o_ready   t_in  i_data
//  out      out  o_valid / i_ready   t_out o_data
//  cfg      in   i_cfg_we            i_cfg_data (resolution)
//
// One item at a time; a new transfer is taken only once the last result is gone.
// Lookup: position division, point walk over the stored points, left point fetch
// and weight division, blend of the three colour lanes, iso walk, then output.
// Insert: stored points above the new position are shifted up one by one, then the
// new point is placed. Other commands go straight to the output state.
// After reset a clearing pass writes every alpha RAM entry and the point RAM;
// no item is taken meanwhile. The result waits in o_data until taken.
`timescale 1ns / 1ps
module transfer_function_colormap import tfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data
);
    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_INS_R = 14'b00000000000100,
        S_INS_C = 14'b00000000001000,
        S_VDIV  = 14'b00000000010000,
        S_WALKR = 14'b00000000100000,
        S_WALKC = 14'b00000001000000,
        S_LFTR  = 14'b00000010000000,
        S_LFTC  = 14'b00000100000000,
        S_WDIV  = 14'b00001000000000,
        S_BLEND = 14'b00010000000000,
        S_ISOR  = 14'b00100000000000,
        S_ISOC  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_st;
    t_in    r_in;
    logic [8:0] r_res;
    logic [MW:0] r_clr;
    logic [PW:0] r_pcnt, r_k;
    logic [IW:0] r_icnt, r_j;
    logic [15:0] r_v, r_alpha;
    t_point r_rp, r_lp;
    logic [15:0] r_w;
    logic [2:0]  r_blk; // blend lane index
    logic [15:0] r_col [3];

    // effective resolution
    logic [8:0] w_res;
    always_comb begin
        if (r_res == 9'd0) w_res = 9'd1;
        else if (r_res > 9'(MAP_MAX)) w_res = 9'(MAP_MAX);
        else w_res = r_res;
    end

    // point RAM
    logic p_we; logic [PW-1:0] p_wa, p_ra; t_point p_wd, p_rd;
    tfc_ram #(.WIDTH($bits(t_point)), .DEPTH(POINT_MAX)) u_pts (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));
    // alpha RAM
    logic a_we; logic [MW-1:0] a_wa; logic [15:0] a_wd, a_rd;
    tfc_ram #(.WIDTH(16), .DEPTH(MAP_MAX)) u_alpha (
        .i_clk, .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd),
        .i_raddr(r_in.entry_index[MW-1:0]), .o_rdata(a_rd));
    // iso RAM read side
    logic [IW-1:0] iso_ra; logic [15:0] iso_rd;

    // shared divider
    logic d_start, d_done; logic [31:0] d_num, d_quo; logic [16:0] d_den;
    tfc_div u_div (.i_clk, .i_rst_n, .i_start(d_start), .i_num(d_num), .i_den(d_den),
        .o_done(d_done), .o_quo(d_quo));

    logic w_idx_bad;
    assign w_idx_bad = {1'b0, i_data.entry_index} >= w_res;

    // status of an item at its transfer
    logic [1:0] w_acc_st;
    always_comb begin
        w_acc_st = ST_OK;
        case (i_data.command)
            CMD_INSERT: if (r_pcnt >= (PW+1)'(POINT_MAX)) w_acc_st = ST_FULL;
            CMD_WALPHA: if (w_idx_bad) w_acc_st = ST_IDX;
            CMD_ADDISO: if (r_icnt >= (IW+1)'(ISO_MAX)) w_acc_st = ST_FULL;
            CMD_LOOKUP: if (w_idx_bad) w_acc_st = ST_IDX;
                else if (r_pcnt == '0) w_acc_st = ST_NOPT;
            default: ;
        endcase
    end

    // blend lane selects
    logic [15:0] w_a, w_b, w_d, w_bl;
    logic [31:0] w_prod;
    always_comb begin
        case (r_blk)
            3'd0: begin w_a = r_lp.r; w_b = r_rp.r; end
            3'd1: begin w_a = r_lp.g; w_b = r_rp.g; end
            default: begin w_a = r_lp.b; w_b = r_rp.b; end
        endcase
        w_d    = (w_b >= w_a) ? (w_b - w_a) : (w_a - w_b);
        w_prod = w_d * r_w;
        w_bl   = (w_b >= w_a) ? (w_a + w_prod[31:16]) : (w_a - w_prod[31:16]);
    end

    // iso band test
    logic [24:0] w_mid_p;
    logic [9:0]  w_mid, w_lo, w_hi;
    logic        w_hit;
    always_comb begin
        w_mid_p = iso_rd * (w_res - 9'd1);
        w_mid   = {2'b0, w_mid_p[23:16]};
        w_lo    = (w_mid == 10'd0) ? 10'd0 : w_mid - 10'd1;
        w_hi    = (w_mid + 10'd2 > {1'b0, w_res} - 10'd1) ? {1'b0, w_res} - 10'd1
                                                            : w_mid + 10'd2;
        w_hit   = ({2'b0, r_in.entry_index} >= w_lo) && ({2'b0, r_in.entry_index} <= w_hi);
    end

    assign o_ready = (r_st == S_IDLE) && !o_valid;

    always_comb begin
        p_we = 1'b0; p_wa = r_k[PW-1:0]; p_wd = p_rd; p_ra = r_k[PW-1:0];
        a_we = 1'b0; a_wa = r_in.entry_index[MW-1:0]; a_wd = r_in.alpha_in;
        iso_ra = r_j[IW-1:0];
        d_start = 1'b0; d_num = '0; d_den = '0;
        unique case (r_st)
            S_INIT: begin
                a_we = 1'b1; a_wa = r_clr[MW-1:0]; a_wd = ALPHA_RST;
                p_we = r_clr < (MW+1)'(POINT_MAX);
                p_wa = r_clr[PW-1:0]; p_wd = rst_point(r_clr[PW-1:0]);
            end
            S_INS_R: p_ra = r_k[PW-1:0] - PW'(1);
            S_INS_C: begin
                // shift point k-1 up, or place new point at k
                if (r_k != '0 && p_rd.pos > r_in.position) begin
                    p_we = 1'b1; p_wa = r_k[PW-1:0]; p_wd = p_rd;
                end else begin
                    p_we = 1'b1; p_wa = r_k[PW-1:0];
                    p_wd = '{r_in.position, r_in.red_in, r_in.green_in, r_in.blue_in};
                end
            end
            S_LFTR: p_ra = r_k[PW-1:0] - PW'(1);
            S_ISOR: iso_ra = r_j[IW-1:0];
            default: ;
        endcase
        if (r_st == S_IDLE && i_valid && o_ready) begin
            if (i_data.command == CMD_WALPHA && !w_idx_bad) begin
                a_we = 1'b1; a_wa = i_data.entry_index[MW-1:0]; a_wd = i_data.alpha_in;
            end
        end
        if (r_st == S_VDIV && !d_done && r_j == '1) begin
            d_start = 1'b1;
            d_num = ({23'b0, r_in.entry_index, 1'b1}) << 16;
            d_den = {7'b0, w_res, 1'b0};
        end
        if (r_st == S_LFTC) begin
            d_start = 1'b1;
            d_num = {r_v - p_rd.pos, 16'b0};
            d_den = {1'b0, r_rp.pos - p_rd.pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_clr <= '0; r_pcnt <= (PW+1)'(3); r_icnt <= '0;
            r_res <= RES_RST; o_valid <= 1'b0; r_k <= '0; r_j <= '0;
        end else begin
            if (i_cfg_we) r_res <= i_cfg_data;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                S_INIT: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (MW+1)'(MAP_MAX - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid && o_ready) begin
                    r_in <= i_data;
                    o_data <= {64'd0, 1'b0, w_acc_st};
                    r_k <= r_pcnt;
                    r_j <= '1;
                    r_st <= (w_acc_st != ST_OK) ? S_OUT :
                            (i_data.command == CMD_INSERT) ? S_INS_R :
                            (i_data.command == CMD_LOOKUP) ? S_VDIV : S_OUT;
                    case (i_data.command)
                        CMD_CLRPTS: r_pcnt <= '0;
                        CMD_ADDISO: if (w_acc_st == ST_OK) r_icnt <= r_icnt + 1'b1;
                        CMD_CLRISO: r_icnt <= '0;
                        default: ;
                    endcase
                end
                S_INS_R: r_st <= S_INS_C;
                S_INS_C: begin
                    if (r_k != '0 && p_rd.pos > r_in.position) begin
                        r_k <= r_k - 1'b1; r_st <= S_INS_R;
                    end else begin
                        r_pcnt <= r_pcnt + 1'b1; r_st <= S_OUT;
                    end
                end
                S_VDIV: begin
                    r_j <= '0;
                    if (d_done) begin
                        r_v <= d_quo[15:0]; r_k <= '0; r_st <= S_WALKR;
                    end
                end
                S_WALKR: r_st <= S_WALKC;
                S_WALKC: begin
                    r_rp <= p_rd;
                    if (r_v > p_rd.pos && r_k + 1'b1 < r_pcnt) begin
                        r_k <= r_k + 1'b1; r_st <= S_WALKR;
                    end else if (r_v > p_rd.pos || r_k == '0) begin
                        // clamp to last or first point
                        r_col[0] <= p_rd.r; r_col[1] <= p_rd.g; r_col[2] <= p_rd.b;
                        r_j <= '0; r_st <= S_ISOR;
                    end else r_st <= S_LFTR;
                end
                S_LFTR: r_st <= S_LFTC;
                S_LFTC: begin r_lp <= p_rd; r_st <= S_WDIV; end
                S_WDIV: if (d_done) begin
                    r_w <= (d_quo > 32'd65535) ? 16'hFFFF : d_quo[15:0];
                    r_blk <= '0; r_st <= S_BLEND;
                end
                S_BLEND: begin
                    r_col[r_blk[1:0]] <= w_bl;
                    r_blk <= r_blk + 1'b1;
                    if (r_blk == 3'd2) begin r_j <= '0; r_st <= S_ISOR; end
                end
                S_ISOR: begin
                    if (r_j == '0) r_alpha <= a_rd;
                    r_st <= (r_j < r_icnt) ? S_ISOC : S_OUT;
                    if (!(r_j < r_icnt))
                        o_data <= {r_col[0], r_col[1], r_col[2],
                                   (r_j == '0) ? a_rd : r_alpha, 1'b1, ST_OK};
                end
                S_ISOC: begin
                    if (w_hit && r_alpha < ISO_ALPHA) r_alpha <= ISO_ALPHA;
                    r_j <= r_j + 1'b1; r_st <= S_ISOR;
                end
                S_OUT: begin o_valid <= 1'b1; r_st <= S_IDLE; end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // iso list written in the cycle after an accepted add
    logic r_iso_pend; logic [IW-1:0] r_iso_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iso_pend <= 1'b0;
        else r_iso_pend <= r_st == S_IDLE && i_valid && o_ready
                && i_data.command == CMD_ADDISO && r_icnt < (IW+1)'(ISO_MAX);
        r_iso_addr <= r_icnt[IW-1:0];
    end
    tfc_ram #(.WIDTH(16), .DEPTH(ISO_MAX)) u_iso (
        .i_clk, .i_we(r_iso_pend), .i_waddr(r_iso_addr),
        .i_wdata(r_in.position), .i_raddr(iso_ra), .o_rdata(iso_rd));

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_st == S_IDLE) else $error("accept while busy");
    a_pcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= (PW+1)'(POINT_MAX)) else $error("point count overflow");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.entry_valid |-> o_data.alpha_out == '0) else $error("stray alpha");
endmodule
